// ----- sv/bb3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants for the 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 4096;

    // line store address and frame counters
    localparam int ADDR_W  = $clog2(MAX_COLUMNS);
    localparam int COLS_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
    localparam int IROW_W  = $clog2(MAX_ROWS + 2);
    localparam int OROW_W  = $clog2(MAX_ROWS);

    // configuration port
    localparam int CFG_COLS_W = 11;
    localparam int CFG_ROWS_W = 13;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [0:0] {
        REG_COLUMN_COUNT = 1'b0,
        REG_ROW_COUNT    = 1'b1
    } cfg_reg_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // mean of nine: floor(x / 9) == (x * 7282) >> 16 for x <= 9 * 255
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // one line store entry: two previous rows at one column
    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } line_t;

    // [row] within a column: 0 oldest, 2 newest
    typedef pixel_t [2:0] win_col_t;
    // [column]: 0 oldest, 2 newest
    typedef win_col_t [2:0] win_t;

    typedef struct packed {
        logic valid;
        logic interior;
        logic last;
    } mean_ctl_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } out_item_t;

endpackage

// ----- sv/box_blur_3x3_rgb_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// 3x3 box blur of an RGB pixel stream with one line store for two rows.
// ----------------------------------------------------------------------------
// Takes one item per clock: a pixel or a drain item enters every cycle while
// in_ready is high, and in_ready only drops when the eight-entry output queue
// plus the items in flight would fill it. The two previous rows sit in one
// 1024 x 48 line store (one read and one write port, one read per item); the
// window, the per-channel sums and the divide by nine follow in three pipeline
// stages (line store read, window, sums), the divide combinational behind the
// sums. Output pixels run one row and one pixel behind the input; after the
// last pixel of the frame, drain items (or pixels, which then count as drains)
// push out the remaining row and one pixel; the last one carries frame_end.
// A configuration write restarts the frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core
    import bb3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration, stored already clamped
    logic [COLS_W-1:0]     cols_reg;
    logic [COLS_W-1:0]     cols_next;
    logic [ROWS_W-1:0]     rows_reg;
    logic [ROWS_W-1:0]     rows_next;
    logic [CFG_COLS_W-1:0] cfg_cols;
    logic [CFG_ROWS_W-1:0] cfg_rows;
    logic                  cfg_fire;

    // frame counters
    logic [ADDR_W-1:0] in_col_reg;
    logic [ADDR_W-1:0] in_col_next;
    logic [IROW_W-1:0] in_row_reg;
    logic [IROW_W-1:0] in_row_next;
    logic [ADDR_W-1:0] out_col_reg;
    logic [ADDR_W-1:0] out_col_next;
    logic [OROW_W-1:0] out_row_reg;
    logic [OROW_W-1:0] out_row_next;

    logic              in_fire;
    logic              tail;
    logic              push;
    logic              emit;
    logic              interior;
    logic              last;
    logic [COLS_W-1:0] in_col_inc;
    logic [COLS_W-1:0] out_col_inc;
    logic [ROWS_W-1:0] out_row_inc;
    pixel_t            pix;

    // line store stage
    logic              b_valid_reg;
    logic              b_emit_reg;
    logic              b_interior_reg;
    logic              b_last_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    pixel_t            b_pix_reg;
    line_t             rd_line;
    line_t             wr_line;

    // window stage
    win_t      win_reg;
    mean_ctl_t c_ctl_reg;
    logic      mean_valid;
    out_item_t mean_item;

    // output queue
    out_item_t             fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_next;
    logic [1:0]            inflight_reg;
    logic [1:0]            inflight_next;
    logic                  out_fire;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_cols  = cfg_data[CFG_COLS_W-1:0];
    assign cfg_rows  = cfg_data[CFG_ROWS_W-1:0];

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_fire)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLUMN_COUNT:
                begin
                    if (cfg_cols == '0)
                        cols_next = COLS_W'(1);
                    else if (cfg_cols > CFG_COLS_W'(MAX_COLUMNS))
                        cols_next = COLS_W'(MAX_COLUMNS);
                    else
                        cols_next = COLS_W'(cfg_cols);
                end
                REG_ROW_COUNT:
                begin
                    if (cfg_rows == '0)
                        rows_next = ROWS_W'(1);
                    else if (cfg_rows > CFG_ROWS_W'(MAX_ROWS))
                        rows_next = ROWS_W'(MAX_ROWS);
                    else
                        rows_next = ROWS_W'(cfg_rows);
                end
                default:
                begin
                    cols_next = cols_reg;
                end
            endcase
        end
    end

    // ---------------- input side ----------------
    assign in_fire = in_valid && in_ready;
    assign tail    = in_row_reg >= IROW_W'(rows_reg);
    assign push    = in_fire && (tail || (in_item.cmd == CMD_PIXEL));
    assign emit    = (in_row_reg >= IROW_W'(2))
                  || ((in_row_reg == IROW_W'(1)) && (in_col_reg != '0));

    assign in_col_inc  = COLS_W'(in_col_reg) + COLS_W'(1);
    assign out_col_inc = COLS_W'(out_col_reg) + COLS_W'(1);
    assign out_row_inc = ROWS_W'(out_row_reg) + ROWS_W'(1);

    assign interior = (out_row_reg != '0) && (out_row_inc < rows_reg)
                   && (out_col_reg != '0) && (out_col_inc < cols_reg);
    assign last     = (out_row_inc >= rows_reg) && (out_col_inc >= cols_reg);

    always_comb
    begin
        if (tail)
        begin
            pix = '0;
        end
        else
        begin
            pix.red   = in_item.in_red;
            pix.green = in_item.in_green;
            pix.blue  = in_item.in_blue;
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_fire)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (push)
        begin
            if (in_col_inc >= cols_reg)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + ADDR_W'(1);
            end
            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_inc >= cols_reg)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= COLS_W'(MAX_COLUMNS);
            rows_reg    <= ROWS_W'(768);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            b_valid_reg <= 1'b0;
            c_ctl_reg   <= '0;
        end
        else
        begin
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            b_valid_reg <= push;
            c_ctl_reg.valid    <= b_valid_reg && b_emit_reg;
            c_ctl_reg.interior <= b_interior_reg;
            c_ctl_reg.last     <= b_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_emit_reg     <= emit;
        b_interior_reg <= interior;
        b_last_reg     <= last;
        b_addr_reg     <= in_col_reg;
        b_pix_reg      <= pix;
    end

    // ---------------- line store and window ----------------
    assign wr_line.older = rd_line.newer;
    assign wr_line.newer = b_pix_reg;

    bb3_line_ram u_line_ram (
        .clk     (clk),
        .rd_en   (push),
        .rd_addr (in_col_reg),
        .wr_en   (b_valid_reg),
        .wr_addr (b_addr_reg),
        .wr_data (wr_line),
        .rd_data (rd_line)
    );

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= rd_line.older;
            win_reg[2][1] <= rd_line.newer;
            win_reg[2][2] <= b_pix_reg;
        end
    end

    bb3_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win_reg),
        .ctl       (c_ctl_reg),
        .out_valid (mean_valid),
        .out_item  (mean_item)
    );

    // ---------------- output queue ----------------
    assign out_valid = fifo_cnt_reg != '0;
    assign out_item  = fifo_mem[rd_ptr_reg];
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = ((FIFO_CNT_W+1)'(fifo_cnt_reg) + (FIFO_CNT_W+1)'(inflight_reg))
                     < (FIFO_CNT_W+1)'(FIFO_DEPTH);

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (mean_valid && !out_fire)
            fifo_cnt_next = fifo_cnt_reg + FIFO_CNT_W'(1);
        else if (!mean_valid && out_fire)
            fifo_cnt_next = fifo_cnt_reg - FIFO_CNT_W'(1);

        inflight_next = inflight_reg;
        if ((push && emit) && !mean_valid)
            inflight_next = inflight_reg + 2'd1;
        else if (!(push && emit) && mean_valid)
            inflight_next = inflight_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            inflight_reg <= inflight_next;
            if (mean_valid)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mean_valid)
        begin
            fifo_mem[wr_ptr_reg] <= mean_item;
        end
    end

endmodule

// ----- sv/bb3_line_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_line_ram
// Dual line store: one write port, one read port, registered read data.
// A read that hits the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module bb3_line_ram
    import bb3_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  line_t             wr_data,
    output line_t             rd_data
);

    line_t mem [MAX_COLUMNS];
    line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/bb3_mean.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_mean
// Window sums per channel, then divide by nine through a reciprocal multiply
// and pick mean or center pixel.
// ----------------------------------------------------------------------------
module bb3_mean
    import bb3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  win_t      win,
    input  mean_ctl_t ctl,
    output logic      out_valid,
    output out_item_t out_item
);

    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;

    logic             d_valid_reg;
    logic             d_interior_reg;
    logic             d_last_reg;
    logic [SUM_W-1:0] d_sum_r_reg;
    logic [SUM_W-1:0] d_sum_g_reg;
    logic [SUM_W-1:0] d_sum_b_reg;
    pixel_t           d_center_reg;

    logic [SUM_W+RECIP_W-1:0] prod_r;
    logic [SUM_W+RECIP_W-1:0] prod_g;
    logic [SUM_W+RECIP_W-1:0] prod_b;

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum_r = sum_r + SUM_W'(win[i][j].red);
                sum_g = sum_g + SUM_W'(win[i][j].green);
                sum_b = sum_b + SUM_W'(win[i][j].blue);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_interior_reg <= ctl.interior;
        d_last_reg     <= ctl.last;
        d_sum_r_reg    <= sum_r;
        d_sum_g_reg    <= sum_g;
        d_sum_b_reg    <= sum_b;
        d_center_reg   <= win[1][1];
    end

    assign prod_r = (SUM_W+RECIP_W)'(d_sum_r_reg) * (SUM_W+RECIP_W)'(RECIP_NINE);
    assign prod_g = (SUM_W+RECIP_W)'(d_sum_g_reg) * (SUM_W+RECIP_W)'(RECIP_NINE);
    assign prod_b = (SUM_W+RECIP_W)'(d_sum_b_reg) * (SUM_W+RECIP_W)'(RECIP_NINE);

    always_comb
    begin
        if (d_interior_reg)
        begin
            out_item.out_red   = prod_r[RECIP_SHIFT +: 8];
            out_item.out_green = prod_g[RECIP_SHIFT +: 8];
            out_item.out_blue  = prod_b[RECIP_SHIFT +: 8];
        end
        else
        begin
            out_item.out_red   = d_center_reg.red;
            out_item.out_green = d_center_reg.green;
            out_item.out_blue  = d_center_reg.blue;
        end
        out_item.frame_end = d_last_reg;
    end

    assign out_valid = d_valid_reg;

endmodule

// ----- bench/box_blur_3x3_rgb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_checker
// Watches the pixel, result and register channels of the 3x3 box blur core.
// ----------------------------------------------------------------------------
// Keeps its own copy of the register values, both line stores, the 3x3 window
// and the input/output frame counters. Every accepted item is run through
// blur_step; each resulting pixel is queued and compared with the next pixel
// the core hands out. Reports the failure count, the number of pixels still
// owed by the core, and how many pixels were compared.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_checker
    import bb3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_item,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_item,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    logic [CFG_COLS_W-1:0] col_reg;
    logic [CFG_ROWS_W-1:0] row_reg;
    pixel_t                older_px [MAX_COLUMNS];
    pixel_t                newer_px [MAX_COLUMNS];
    pixel_t                win [3][3];    // [column][row], 0 oldest
    int unsigned           in_row;
    int unsigned           in_col;
    int unsigned           out_row;
    int unsigned           out_col;
    out_item_t             expected_pixels [$];

    function automatic void clear_counters();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    // one item in, at most one blurred or passed-through pixel out
    function automatic bit blur_step(input in_item_t it, output out_item_t res);
        int unsigned ncols;
        int unsigned nrows;
        int unsigned slot;
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int          i;
        int          j;
        pixel_t      pix;
        bit          emit;
        bit          interior;

        ncols = (col_reg == 0) ? 1 : ((col_reg > MAX_COLUMNS) ? MAX_COLUMNS : col_reg);
        nrows = (row_reg == 0) ? 1 : ((row_reg > MAX_ROWS) ? MAX_ROWS : row_reg);
        pix   = '0;
        res   = '0;

        if (in_row < nrows)
        begin
            if (it.cmd == CMD_DRAIN)
                return 1'b0;
            pix.red   = it.in_red;
            pix.green = it.in_green;
            pix.blue  = it.in_blue;
        end
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);

        slot = (in_col >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : in_col;
        win[0] = win[1];
        win[1] = win[2];
        win[2][0] = older_px[slot];
        win[2][1] = newer_px[slot];
        win[2][2] = pix;
        older_px[slot] = newer_px[slot];
        newer_px[slot] = pix;
        in_col++;
        if (in_col >= ncols)
        begin
            in_col = 0;
            in_row++;
        end

        if (!emit)
            return 1'b0;

        interior = out_row >= 1 && out_row + 1 < nrows && out_col >= 1 && out_col + 1 < ncols;
        if (interior)
        begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                begin
                    sum_r += win[i][j].red;
                    sum_g += win[i][j].green;
                    sum_b += win[i][j].blue;
                end
            res.out_red   = 8'(sum_r / 9);
            res.out_green = 8'(sum_g / 9);
            res.out_blue  = 8'(sum_b / 9);
        end
        else
        begin
            res.out_red   = win[1][1].red;
            res.out_green = win[1][1].green;
            res.out_blue  = win[1][1].blue;
        end

        if (out_row + 1 >= nrows && out_col + 1 >= ncols)
        begin
            res.frame_end = 1'b1;
            clear_counters();
        end
        else
        begin
            out_col++;
            if (out_col >= ncols)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;

        if (!rst_n)
        begin
            col_reg = CFG_COLS_W'(1024);
            row_reg = CFG_ROWS_W'(768);
            foreach (older_px[k])
            begin
                older_px[k] = '0;
                newer_px[k] = '0;
            end
            win = '{default: '0};
            clear_counters();
            expected_pixels.delete();
            fail_count = 0;
            checked    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected pixel r=%02h g=%02h b=%02h end=%0b",
                             $time, out_item.out_red, out_item.out_green,
                             out_item.out_blue, out_item.frame_end);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (out_item.out_red !== want.out_red ||
                        out_item.out_green !== want.out_green ||
                        out_item.out_blue !== want.out_blue ||
                        out_item.frame_end !== want.frame_end)
                    begin
                        fail_count++;
                        $display({"%0t: pixel %0d expected r=%02h g=%02h b=%02h end=%0b,",
                                  " got r=%02h g=%02h b=%02h end=%0b"},
                                 $time, checked, want.out_red, want.out_green,
                                 want.out_blue, want.frame_end, out_item.out_red,
                                 out_item.out_green, out_item.out_blue,
                                 out_item.frame_end);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_COLUMN_COUNT)
                    col_reg = cfg_data[CFG_COLS_W-1:0];
                else
                    row_reg = cfg_data[CFG_ROWS_W-1:0];
                clear_counters();
            end

            if (in_valid && in_ready && blur_step(in_item, want))
                expected_pixels.push_back(want);
        end
        pending = expected_pixels.size();
    end

endmodule

// ----- bench/box_blur_3x3_rgb_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core_tb
// Stimulus and verdict for the 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
// Drives raster frames of random pixels with their drain tails, mixed with
// ignored drains, pixels that stand in for drains, and frames cut short by a
// register write. A short directed opening covers one-pixel frames, register
// masking and the clamping of zero, and extreme pixel values. Three random phases
// vary sender and receiver idling; the last one also starts frames at the
// saturated width and height and runs a frame with a long receiver stall and
// a sender pause. Checking is done by box_blur_3x3_rgb_checker.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core_tb;
    import bb3_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 120;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int ecols;
    int erows;
    bit frame_cut;
    int n_pixels;
    int n_drains;
    int n_useful;
    int n_writes;
    int n_frames;
    int idle_cycles = 0;

    box_blur_3x3_rgb_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    box_blur_3x3_rgb_checker blur_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px.red   = rand_chan();
        px.green = rand_chan();
        px.blue  = rand_chan();
        return px;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_item(input logic cmd, input pixel_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{cmd: cmd, in_red: px.red, in_green: px.green, in_blue: px.blue};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (cmd == CMD_PIXEL)
            n_pixels++;
        else
            n_drains++;
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        drain_wait();
        // drains that made no pixel may still be in the pipeline
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_writes++;
        if (idx == REG_COLUMN_COUNT)
        begin
            ecols = val[CFG_COLS_W-1:0];
            if (ecols == 0)
                ecols = 1;
            else if (ecols > MAX_COLUMNS)
                ecols = MAX_COLUMNS;
        end
        else
        begin
            erows = val[CFG_ROWS_W-1:0];
            if (erows == 0)
                erows = 1;
            else if (erows > MAX_ROWS)
                erows = MAX_ROWS;
        end
    endtask

    task automatic reconfigure();
        int pick;
        int p;
        int c;
        int r;
        pick = $urandom_range(2);
        p = $urandom_range(99);
        if (p < 4)
            c = 0;
        else if (p < 70)
            c = $urandom_range(1, 8);
        else if (p < 93)
            c = $urandom_range(9, 40);
        else
            c = $urandom_range(41, 120);
        if (pick != 1)
            write_reg(REG_COLUMN_COUNT, {2'($urandom_range(3)), 11'(c)});
        p = $urandom_range(99);
        if (p < 4)
            r = 0;
        else if (ecols > 40)
            r = $urandom_range(1, 3);
        else if (p < 80)
            r = $urandom_range(1, 6);
        else
            r = $urandom_range(7, 14);
        if (pick != 0)
            write_reg(REG_ROW_COUNT, 13'(r));
    endtask

    // one frame of pixels plus its tail; may stop early when may_cut is set
    task automatic run_frame(input int hold_at, input int pause_at, input bit may_cut);
        int cells;
        int total;
        int stop_at;
        int k;
        cells   = ecols * erows;
        total   = cells + ecols + 1;
        stop_at = (may_cut && $urandom_range(99) < 8) ? $urandom_range(total - 1) : total;
        frame_cut = (stop_at < total);
        if ($urandom_range(99) < 5)
            push_item(CMD_DRAIN, rand_pixel());
        for (k = 0; k < stop_at; k++)
        begin
            if (k == hold_at)
                hold_left = LONG_HOLD;
            if (k == pause_at)
                drain_wait();
            if (k < cells)
            begin
                if ($urandom_range(99) < 3)
                    push_item(CMD_DRAIN, rand_pixel());
                push_item(CMD_PIXEL, rand_pixel());
            end
            else
                push_item(($urandom_range(3) == 0) ? CMD_PIXEL : CMD_DRAIN, rand_pixel());
            n_useful++;
        end
        if (!frame_cut)
            n_frames++;
    endtask

    task automatic run_phase(input int target);
        int goal;
        int cells;
        goal = n_useful + target;
        while (n_useful < goal)
        begin
            if (frame_cut || $urandom_range(99) < 35)
                reconfigure();
            cells = ecols * erows;
            run_frame(($urandom_range(99) < 4) ? int'($urandom_range(cells)) : -1,
                      ($urandom_range(99) < 4) ? int'($urandom_range(cells)) : -1, 1'b1);
        end
    endtask

    initial
    begin
        int     k;
        pixel_t px;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_COLUMN_COUNT;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        ecols         = 1024;
        erows         = 768;
        frame_cut     = 1'b0;
        n_pixels      = 0;
        n_drains      = 0;
        n_useful      = 0;
        n_writes      = 0;
        n_frames      = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset geometry: a few pixels, far from any output
        for (k = 0; k < 3; k++)
            push_item(CMD_PIXEL, rand_pixel());

        // column value with unused high bits, masks to zero; both count as one
        write_reg(REG_COLUMN_COUNT, 13'h1800);
        write_reg(REG_ROW_COUNT, 13'h0000);
        push_item(CMD_DRAIN, '{8'hFF, 8'hFF, 8'hFF});
        push_item(CMD_PIXEL, '{8'hFF, 8'h00, 8'hFF});
        push_item(CMD_PIXEL, '{8'h00, 8'hFF, 8'h00});
        push_item(CMD_DRAIN, '{8'h00, 8'h00, 8'h00});

        write_reg(REG_COLUMN_COUNT, 13'd3);
        write_reg(REG_ROW_COUNT, 13'd3);
        for (k = 0; k < 9; k++)
        begin
            if (k == 5)
                push_item(CMD_DRAIN, rand_pixel());
            px.red   = k[0] ? 8'hFF : 8'h00;
            px.green = k[0] ? 8'h00 : 8'hFF;
            px.blue  = 8'(k * 31);
            push_item(CMD_PIXEL, px);
        end
        for (k = 0; k < 4; k++)
            push_item(k[0] ? CMD_PIXEL : CMD_DRAIN, '{8'h5A, 8'hA5, 8'hFF});
        push_item(CMD_DRAIN, rand_pixel());

        send_idle_pct = 13;
        recv_idle_pct = 48;
        run_phase(450);

        send_idle_pct = 48;
        recv_idle_pct = 13;
        run_phase(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // saturated width, then saturated height; each frame cut by the next write
        write_reg(REG_COLUMN_COUNT, 13'h07FF);
        write_reg(REG_ROW_COUNT, 13'd3);
        for (k = 0; k < 16; k++)
            push_item(CMD_PIXEL, rand_pixel());
        write_reg(REG_COLUMN_COUNT, 13'd1);
        write_reg(REG_ROW_COUNT, 13'h1FFF);
        for (k = 0; k < 16; k++)
            push_item(CMD_PIXEL, rand_pixel());
        // long receiver stall and a sender pause inside one frame
        write_reg(REG_COLUMN_COUNT, 13'd40);
        write_reg(REG_ROW_COUNT, 13'd5);
        run_frame(60, 150, 1'b0);
        run_phase(450);

        drain_wait();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Sent %0d pixels and %0d drain items, %0d whole frames, %0d register writes.",
                 n_pixels, n_drains, n_frames, n_writes);
        $display("Compared %0d output pixels; sizes from one pixel up to saturated registers.",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
